@@ hdl/prra_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prra_pkg
// Shared constants, codes and types of the packet reorder and reassembly block.
// ----------------------------------------------------------------------------
package prra_pkg;

    localparam int SEQ_BITS     = 32;
    localparam int CNT_BITS     = 5;
    localparam int POS_BITS     = 4;
    localparam int HANDLE_BITS  = 10;
    localparam int WINDOW       = 16;
    localparam int WIN_BITS     = 4;
    localparam int MAX_FRAGS    = 16;
    localparam int RESULT_LIMIT = 32;
    localparam int NRES_BITS    = 6;
    localparam int GROUPS_DEF   = 4;

    typedef enum logic {
        KIND_FRAG = 1'b0,
        KIND_DROP = 1'b1
    } t_kind;

    typedef enum logic [2:0] {
        RSN_NONE    = 3'd0,
        RSN_OLD     = 3'd1,
        RSN_DUPFRAG = 3'd2,
        RSN_BEYOND  = 3'd3,
        RSN_BADPOS  = 3'd4
    } t_reason;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_CHK,
        ST_EMIT,
        ST_FIN
    } t_state;

    typedef struct packed {
        t_kind                  kind;
        t_reason                reason;
        logic [SEQ_BITS-1:0]    seq;
        logic [HANDLE_BITS-1:0] handle;
        logic [POS_BITS-1:0]    idx;
        logic                   last_of_packet;
        logic                   last;
    } t_result;

    typedef struct packed {
        logic                we;
        logic [SEQ_BITS-1:0] value;
    } t_cfg_wr;

endpackage

@@ hdl/prra_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prra_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module prra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ hdl/prra_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prra_ctrl
// Item sequencer: window check, fragment group table and in-order release.
// ----------------------------------------------------------------------------
module prra_ctrl #(
    parameter int GROUPS = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [prra_pkg::SEQ_BITS-1:0]    i_seq_number,
    input  logic [prra_pkg::CNT_BITS-1:0]    i_frag_count,
    input  logic [prra_pkg::POS_BITS-1:0]    i_frag_pos,
    input  logic [prra_pkg::SEQ_BITS-1:0]    i_group_id,
    input  logic [prra_pkg::HANDLE_BITS-1:0] i_payload_handle,
    input  prra_pkg::t_cfg_wr                i_cfg,
    output logic                             o_busy,
    output logic                             o_valid,
    output prra_pkg::t_result                o_result
);
    import prra_pkg::*;

    localparam int GW  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int GAW = $clog2(GROUPS * MAX_FRAGS);

    t_state r_state, n_state;

    logic [SEQ_BITS-1:0]    r_base, n_base;
    logic [WINDOW-1:0]      r_valid, n_valid;
    logic [POS_BITS-1:0]    r_dpos, n_dpos;
    logic [NRES_BITS-1:0]   r_n, n_n;

    logic [SEQ_BITS-1:0]    r_seq, n_seq;
    logic [CNT_BITS-1:0]    r_cnt, n_cnt;
    logic [POS_BITS-1:0]    r_pos, n_pos;
    logic [SEQ_BITS-1:0]    r_gid, n_gid;
    logic [HANDLE_BITS-1:0] r_hnd, n_hnd;

    logic                   r_gv     [GROUPS], n_gv     [GROUPS];
    logic [SEQ_BITS-1:0]    r_gkey   [GROUPS], n_gkey   [GROUPS];
    logic [CNT_BITS-1:0]    r_gsize  [GROUPS], n_gsize  [GROUPS];
    logic [MAX_FRAGS-1:0]   r_gpres  [GROUPS], n_gpres  [GROUPS];
    logic [SEQ_BITS-1:0]    r_gfirst [GROUPS], n_gfirst [GROUPS];
    logic                   r_ginwin [GROUPS], n_ginwin [GROUPS];
    logic [WIN_BITS-1:0]    r_gwslot [GROUPS], n_gwslot [GROUPS];

    logic                   r_pv, n_pv;
    t_result                r_pend, n_pend;
    logic                   r_ov, n_ov;
    t_result                r_out, n_out;

    // Memory ports.
    logic                   win_we;
    logic [WIN_BITS-1:0]    win_waddr, win_raddr;
    logic [HANDLE_BITS-1:0] win_rdata;
    logic                   grp_we;
    logic [GAW-1:0]         grp_waddr, grp_raddr;
    logic [HANDLE_BITS-1:0] grp_rdata;

    // Evaluation and delivery helpers.
    logic [WIN_BITS-1:0]    slot_nx;
    logic [SEQ_BITS-1:0]    first_nx;
    logic                   f_hit, e_hit, d_hit;
    logic [GW-1:0]          f_idx, e_idx, d_idx, e_g, sel_g;
    logic                   alloc;
    logic [CNT_BITS-1:0]    size_eff, sel_size;
    logic [MAX_FRAGS-1:0]   pres_eff, newp, full;
    logic [SEQ_BITS-1:0]    fs;
    logic                   do_push, done;
    t_result                push_r;
    logic [POS_BITS-1:0]    off;
    logic [SEQ_BITS:0]      diff_in, diff_fs;

    prra_ram #(.WIDTH(HANDLE_BITS), .DEPTH(WINDOW)) u_win_ram (
        .i_clk  (i_clk),
        .i_we   (win_we),
        .i_waddr(win_waddr),
        .i_wdata(r_hnd),
        .i_raddr(win_raddr),
        .o_rdata(win_rdata)
    );

    prra_ram #(.WIDTH(HANDLE_BITS), .DEPTH(GROUPS * MAX_FRAGS)) u_grp_ram (
        .i_clk  (i_clk),
        .i_we   (grp_we),
        .i_waddr(grp_waddr),
        .i_wdata(r_hnd),
        .i_raddr(grp_raddr),
        .o_rdata(grp_rdata)
    );

    assign slot_nx  = WIN_BITS'(r_base + SEQ_BITS'(1));
    assign first_nx = r_base + SEQ_BITS'(1);

    // Group lookups: matching key, first free entry, window owner of the next slot.
    always_comb begin
        f_hit = 1'b0;
        f_idx = '0;
        e_hit = 1'b0;
        e_idx = '0;
        d_hit = 1'b0;
        d_idx = '0;
        for (int g = 0; g < GROUPS; g++) begin
            if (r_gv[g] && r_gkey[g] == r_gid && !f_hit) begin
                f_hit = 1'b1;
                f_idx = GW'(g);
            end
            if (!r_gv[g] && !e_hit) begin
                e_hit = 1'b1;
                e_idx = GW'(g);
            end
            if (r_ginwin[g] && r_gwslot[g] == slot_nx) begin
                d_hit = 1'b1;
                d_idx = GW'(g);
            end
        end
    end

    assign alloc     = !f_hit && e_hit;
    assign e_g       = f_hit ? f_idx : e_idx;
    assign sel_g     = (r_state == ST_EVAL) ? e_g : d_idx;
    assign sel_size  = r_gsize[sel_g];
    assign size_eff  = alloc ? r_cnt : sel_size;
    assign pres_eff  = alloc ? '0 : r_gpres[sel_g];
    assign newp      = pres_eff | (MAX_FRAGS'(1) << r_pos);
    assign full      = MAX_FRAGS'((17'(1) << size_eff) - 17'(1));
    assign fs        = (r_pos == '0) ? r_seq : r_gfirst[sel_g];
    assign diff_in   = {1'b0, r_seq} - {1'b0, r_base};
    assign diff_fs   = {1'b0, fs} - {1'b0, r_base};
    assign done      = ({1'b0, r_dpos} + CNT_BITS'(1)) >= sel_size;

    assign win_waddr = (r_state == ST_EVAL && r_cnt == '0) ? WIN_BITS'(r_seq) : WIN_BITS'(fs);
    assign win_raddr = slot_nx;
    assign grp_waddr = GAW'({e_g, r_pos});
    assign grp_raddr = GAW'({d_idx, r_dpos});

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_start) n_state = ST_EVAL;
            ST_EVAL: n_state = ST_CHK;
            ST_CHK: begin
                if (r_valid[slot_nx] && r_n < NRES_BITS'(RESULT_LIMIT)) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_EMIT: n_state = ST_CHK;
            ST_FIN:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        n_base   = r_base;
        n_valid  = r_valid;
        n_dpos   = r_dpos;
        n_n      = r_n;
        n_seq    = r_seq;
        n_cnt    = r_cnt;
        n_pos    = r_pos;
        n_gid    = r_gid;
        n_hnd    = r_hnd;
        n_gv     = r_gv;
        n_gkey   = r_gkey;
        n_gsize  = r_gsize;
        n_gpres  = r_gpres;
        n_gfirst = r_gfirst;
        n_ginwin = r_ginwin;
        n_gwslot = r_gwslot;
        n_pv     = r_pv;
        n_pend   = r_pend;
        n_ov     = 1'b0;
        n_out    = r_out;
        win_we   = 1'b0;
        grp_we   = 1'b0;
        do_push  = 1'b0;
        push_r   = '{kind: KIND_DROP, reason: RSN_NONE, seq: r_seq, handle: r_hnd,
                     idx: r_pos, last_of_packet: 1'b0, last: 1'b0};
        off      = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_cfg.we) begin
                    n_base  = i_cfg.value;
                    n_valid = '0;
                    n_dpos  = '0;
                    for (int g = 0; g < GROUPS; g++) begin
                        n_gv[g]     = 1'b0;
                        n_gpres[g]  = '0;
                        n_ginwin[g] = 1'b0;
                    end
                end
                if (i_start) begin
                    n_seq = i_seq_number;
                    n_cnt = i_frag_count;
                    n_pos = i_frag_pos;
                    n_gid = i_group_id;
                    n_hnd = i_payload_handle;
                    n_n   = '0;
                end
            end
            ST_EVAL: begin
                if (r_cnt > CNT_BITS'(MAX_FRAGS) ||
                    (r_cnt != '0 && {1'b0, r_pos} >= r_cnt)) begin
                    push_r.reason = RSN_BADPOS;
                end else if (r_seq <= r_base) begin
                    push_r.reason = RSN_OLD;
                end else if (diff_in > (SEQ_BITS+1)'(WINDOW)) begin
                    push_r.reason = RSN_BEYOND;
                end else if (r_cnt == '0) begin
                    if (r_valid[WIN_BITS'(r_seq)]) begin
                        push_r.reason = RSN_OLD;
                    end else begin
                        n_valid[WIN_BITS'(r_seq)] = 1'b1;
                        win_we = 1'b1;
                    end
                end else begin
                    if (alloc) begin
                        n_gv[e_g]    = 1'b1;
                        n_gkey[e_g]  = r_gid;
                        n_gsize[e_g] = r_cnt;
                        n_gpres[e_g] = '0;
                    end
                    if (!f_hit && !e_hit) begin
                        push_r.reason = RSN_BADPOS;
                    end else if ({1'b0, r_pos} >= size_eff) begin
                        push_r.reason = RSN_BADPOS;
                    end else if (pres_eff[r_pos]) begin
                        push_r.reason = RSN_DUPFRAG;
                    end else begin
                        n_gpres[e_g] = newp;
                        grp_we = 1'b1;
                        if (r_pos == '0) begin
                            n_gfirst[e_g] = r_seq;
                        end
                        if (newp == full) begin
                            if (fs <= r_base || diff_fs > (SEQ_BITS+1)'(WINDOW) ||
                                r_valid[WIN_BITS'(fs)]) begin
                                n_gv[e_g]     = 1'b0;
                                n_gpres[e_g]  = '0;
                                n_ginwin[e_g] = 1'b0;
                                push_r.reason = RSN_OLD;
                            end else begin
                                n_valid[WIN_BITS'(fs)] = 1'b1;
                                n_ginwin[e_g] = 1'b1;
                                n_gwslot[e_g] = WIN_BITS'(fs);
                            end
                        end
                    end
                end
                do_push = (push_r.reason != RSN_NONE);
            end
            ST_CHK: begin
                // Memory reads for the next slot are issued here.
            end
            ST_EMIT: begin
                do_push              = 1'b1;
                push_r.kind          = KIND_FRAG;
                push_r.reason        = RSN_NONE;
                push_r.seq           = first_nx;
                if (!d_hit) begin
                    n_valid[slot_nx]      = 1'b0;
                    push_r.handle         = win_rdata;
                    push_r.idx            = '0;
                    push_r.last_of_packet = 1'b1;
                    n_dpos = '0;
                    n_base = r_base + SEQ_BITS'(1);
                end else begin
                    push_r.handle         = grp_rdata;
                    push_r.idx            = r_dpos;
                    push_r.last_of_packet = done;
                    if (done) begin
                        n_valid[slot_nx] = 1'b0;
                        n_gv[d_idx]     = 1'b0;
                        n_gpres[d_idx]  = '0;
                        n_ginwin[d_idx] = 1'b0;
                        // Slots skipped by a multi-sequence packet are discarded.
                        for (int j = 0; j < WINDOW; j++) begin
                            off = WIN_BITS'(j) - slot_nx;
                            if (off != '0 && {1'b0, off} < sel_size) begin
                                n_valid[j] = 1'b0;
                            end
                        end
                        for (int g = 0; g < GROUPS; g++) begin
                            off = r_gwslot[g] - slot_nx;
                            if (r_ginwin[g] && off != '0 && {1'b0, off} < sel_size) begin
                                n_gv[g]     = 1'b0;
                                n_gpres[g]  = '0;
                                n_ginwin[g] = 1'b0;
                            end
                        end
                        n_dpos = '0;
                        n_base = r_base + SEQ_BITS'(sel_size);
                    end else begin
                        n_dpos = r_dpos + POS_BITS'(1);
                    end
                end
            end
            ST_FIN: begin
                if (r_pv) begin
                    n_ov       = 1'b1;
                    n_out      = r_pend;
                    n_out.last = 1'b1;
                    n_pv       = 1'b0;
                end
            end
            default: ;
        endcase

        // A result is held back until the next one or the finish so that its last flag is known.
        if (do_push) begin
            if (r_pv) begin
                n_ov       = 1'b1;
                n_out      = r_pend;
                n_out.last = 1'b0;
            end
            n_pend = push_r;
            n_pv   = 1'b1;
            n_n    = r_n + NRES_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_base  <= '0;
            r_valid <= '0;
            r_dpos  <= '0;
            r_n     <= '0;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
            for (int g = 0; g < GROUPS; g++) begin
                r_gv[g]     <= 1'b0;
                r_gpres[g]  <= '0;
                r_ginwin[g] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            r_base  <= n_base;
            r_valid <= n_valid;
            r_dpos  <= n_dpos;
            r_n     <= n_n;
            r_pv    <= n_pv;
            r_ov    <= n_ov;
            r_gv    <= n_gv;
            r_gpres <= n_gpres;
            r_ginwin <= n_ginwin;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seq    <= n_seq;
        r_cnt    <= n_cnt;
        r_pos    <= n_pos;
        r_gid    <= n_gid;
        r_hnd    <= n_hnd;
        r_gkey   <= n_gkey;
        r_gsize  <= n_gsize;
        r_gfirst <= n_gfirst;
        r_gwslot <= n_gwslot;
        r_pend   <= n_pend;
        r_out    <= n_out;
    end

    assign o_busy   = (r_state != ST_IDLE);
    assign o_valid  = r_ov;
    assign o_result = r_out;
endmodule

@@ hdl/packet_reorder_reassembly_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_reorder_reassembly_top
// Reorder window with fragment group reassembly and an APB register port.
// ----------------------------------------------------------------------------
// Sequence: each item is evaluated and then checked; each released fragment takes a
// window/handle memory read, then emit, and the final result is released from
// the finish state once the sequencer has no more to release.
// A new item is taken only while the sequencer is idle (busy low).
// Reset: synchronous, clears window, group table, cursor and base to zero.
// Results cannot be stalled; each is shown for one cycle under o_valid.
module packet_reorder_reassembly_top #(
    parameter int GROUPS = prra_pkg::GROUPS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [prra_pkg::SEQ_BITS-1:0]    i_seq_number,
    input  logic [prra_pkg::CNT_BITS-1:0]    i_frag_count,
    input  logic [prra_pkg::POS_BITS-1:0]    i_frag_pos,
    input  logic [prra_pkg::SEQ_BITS-1:0]    i_group_id,
    input  logic [prra_pkg::HANDLE_BITS-1:0] i_payload_handle,
    output logic                             o_valid,
    output logic                             o_kind,
    output logic [2:0]                       o_drop_reason,
    output logic [prra_pkg::SEQ_BITS-1:0]    o_packet_seq,
    output logic [prra_pkg::HANDLE_BITS-1:0] o_fragment_handle,
    output logic [prra_pkg::POS_BITS-1:0]    o_fragment_index,
    output logic                             o_last_of_packet,
    output logic                             o_last,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [1:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import prra_pkg::*;

    logic [SEQ_BITS-1:0] r_start_seq;
    t_cfg_wr             cfg;
    t_result             res;

    // Only one register exists, so every word address maps onto it.
    assign pready    = 1'b1;
    assign cfg.we    = psel && penable && pwrite && (paddr[1:0] == 2'b00 || 1'b1);
    assign cfg.value = pwdata;
    assign prdata    = r_start_seq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_seq <= '0;
        end else if (cfg.we) begin
            r_start_seq <= pwdata;
        end
    end

    prra_ctrl #(.GROUPS(GROUPS)) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_seq_number    (i_seq_number),
        .i_frag_count    (i_frag_count),
        .i_frag_pos      (i_frag_pos),
        .i_group_id      (i_group_id),
        .i_payload_handle(i_payload_handle),
        .i_cfg           (cfg),
        .o_busy          (busy),
        .o_valid         (o_valid),
        .o_result        (res)
    );

    assign o_kind            = res.kind;
    assign o_drop_reason     = res.reason;
    assign o_packet_seq      = res.seq;
    assign o_fragment_handle = res.handle;
    assign o_fragment_index  = res.idx;
    assign o_last_of_packet  = res.last_of_packet;
    assign o_last            = res.last;
endmodule

@@ hdl/prra_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prra_checker
// Port-level checks of the packet reorder and reassembly block.
// ----------------------------------------------------------------------------
module prra_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_valid,
    input logic       o_kind,
    input logic [2:0] o_drop_reason,
    input logic       o_last_of_packet,
    input logic       o_last
);
    import prra_pkg::*;

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not make the block busy");

    a_drop_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_DROP |-> o_drop_reason != RSN_NONE && !o_last_of_packet)
        else $error("drop report without reason or with end of packet");

    a_frag_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_FRAG |-> o_drop_reason == RSN_NONE)
        else $error("delivered fragment carries a drop reason");

    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |=> !o_valid)
        else $error("result follows the final result of an item at once");
endmodule

bind packet_reorder_reassembly_top prra_checker u_prra_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_valid         (o_valid),
    .o_kind          (o_kind),
    .o_drop_reason   (o_drop_reason),
    .o_last_of_packet(o_last_of_packet),
    .o_last          (o_last)
);

@@ sim/packet_reorder_reassembly_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_reorder_reassembly_top_tb
// Drives packet descriptors into the reorder and reassembly block and checks
// every released fragment and drop report against an in-bench model of the
// reorder window and fragment group table, across several start sequences.
// ----------------------------------------------------------------------------
module packet_reorder_reassembly_top_tb;
    import prra_pkg::*;

    localparam int NGROUPS = GROUPS_DEF;

    typedef struct {
        logic [SEQ_BITS-1:0]    seq;
        logic [CNT_BITS-1:0]    cnt;
        logic [POS_BITS-1:0]    pos;
        logic [SEQ_BITS-1:0]    gid;
        logic [HANDLE_BITS-1:0] hnd;
        int                     gap;
        bit                     hold;
    } t_pkt;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic [SEQ_BITS-1:0]    i_seq_number = '0;
    logic [CNT_BITS-1:0]    i_frag_count = '0;
    logic [POS_BITS-1:0]    i_frag_pos = '0;
    logic [SEQ_BITS-1:0]    i_group_id = '0;
    logic [HANDLE_BITS-1:0] i_payload_handle = '0;
    logic                   o_valid;
    logic                   o_kind;
    logic [2:0]             o_drop_reason;
    logic [SEQ_BITS-1:0]    o_packet_seq;
    logic [HANDLE_BITS-1:0] o_fragment_handle;
    logic [POS_BITS-1:0]    o_fragment_index;
    logic                   o_last_of_packet;
    logic                   o_last;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [1:0]             paddr = '0;
    logic [31:0]            pwdata = '0;
    logic [31:0]            prdata;
    logic                   pready;

    packet_reorder_reassembly_top i_dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Model of the reorder window and the group table.
    logic [SEQ_BITS-1:0]    base_seq;
    int                     cursor;
    bit                     win_valid [WINDOW];
    logic [HANDLE_BITS-1:0] win_hnd   [WINDOW];
    bit                     win_grp   [WINDOW];
    int                     win_slot  [WINDOW];
    int                     win_cnt   [WINDOW];
    bit                     grp_valid [NGROUPS];
    logic [SEQ_BITS-1:0]    grp_key   [NGROUPS];
    int                     grp_size  [NGROUPS];
    logic [15:0]            grp_have  [NGROUPS];
    logic [SEQ_BITS-1:0]    grp_first [NGROUPS];
    logic [HANDLE_BITS-1:0] grp_hnd   [NGROUPS][MAX_FRAGS];

    t_result expected_q[$];
    t_pkt    pending_q[$];
    int      errors = 0;
    int      accepted = 0;
    int      results_seen = 0;
    int      drops_seen = 0;

    function automatic void clear_tables();
        for (int i = 0; i < WINDOW; i++) begin
            win_valid[i] = 0;
            win_grp[i] = 0;
        end
        for (int g = 0; g < NGROUPS; g++) begin
            grp_valid[g] = 0;
            grp_have[g] = '0;
        end
        cursor = 0;
    endfunction

    function automatic void clear_slot(int s);
        if (win_valid[s] && win_grp[s]) begin
            grp_valid[win_slot[s]] = 0;
            grp_have[win_slot[s]] = '0;
        end
        win_valid[s] = 0;
    endfunction

    function automatic void advance_base(int c);
        int span;
        span = (c < WINDOW) ? c : WINDOW;
        for (int i = 1; i < span; i++)
            clear_slot(int'((base_seq + 32'd1 + 32'(i)) % WINDOW));
        base_seq = base_seq + 32'(c);
    endfunction

    function automatic void push_result(t_kind k, t_reason r, logic [31:0] sq,
                                        logic [9:0] h, logic [3:0] ix, logic lp);
        t_result res;
        res.kind = k;
        res.reason = r;
        res.seq = sq;
        res.handle = h;
        res.idx = ix;
        res.last_of_packet = lp;
        res.last = 1'b0;
        expected_q.insert(expected_q.size(), res);
    endfunction

    function automatic void predict_step(t_pkt p);
        t_reason     rsn;
        int          n, s, g, found, freeg, sz, c;
        logic [32:0] seq_gap;
        logic [16:0] full;
        logic [31:0] fs;
        logic [9:0]  h;
        bit          done;
        rsn = RSN_NONE;
        n = 0;
        seq_gap = {1'b0, p.seq} - {1'b0, base_seq};
        if (p.cnt > MAX_FRAGS || (p.cnt > 0 && p.pos >= p.cnt)) begin
            rsn = RSN_BADPOS;
        end else if (p.seq <= base_seq) begin
            rsn = RSN_OLD;
        end else if (seq_gap > WINDOW) begin
            rsn = RSN_BEYOND;
        end else if (p.cnt == 0) begin
            s = int'(p.seq[WIN_BITS-1:0]);
            if (win_valid[s]) begin
                rsn = RSN_OLD;
            end else begin
                win_valid[s] = 1;
                win_hnd[s] = p.hnd;
                win_grp[s] = 0;
                win_slot[s] = 0;
                win_cnt[s] = 0;
            end
        end else begin
            found = NGROUPS;
            freeg = NGROUPS;
            for (g = 0; g < NGROUPS; g++) begin
                if (grp_valid[g] && grp_key[g] == p.gid && found == NGROUPS) found = g;
                if (!grp_valid[g] && freeg == NGROUPS) freeg = g;
            end
            if (found == NGROUPS && freeg < NGROUPS) begin
                found = freeg;
                grp_valid[found] = 1;
                grp_key[found] = p.gid;
                grp_size[found] = p.cnt;
                grp_have[found] = '0;
            end
            if (found == NGROUPS || p.pos >= grp_size[found]) begin
                rsn = RSN_BADPOS;
            end else if (grp_have[found][p.pos]) begin
                rsn = RSN_DUPFRAG;
            end else begin
                sz = grp_size[found];
                full = (17'd1 << sz) - 17'd1;
                grp_have[found][p.pos] = 1'b1;
                grp_hnd[found][p.pos] = p.hnd;
                if (p.pos == 0) grp_first[found] = p.seq;
                if (grp_have[found] == full[15:0]) begin
                    fs = grp_first[found];
                    s = int'(fs[WIN_BITS-1:0]);
                    seq_gap = {1'b0, fs} - {1'b0, base_seq};
                    if (fs <= base_seq || seq_gap > WINDOW || win_valid[s]) begin
                        grp_valid[found] = 0;
                        grp_have[found] = '0;
                        rsn = RSN_OLD;
                    end else begin
                        win_valid[s] = 1;
                        win_hnd[s] = '0;
                        win_grp[s] = 1;
                        win_slot[s] = found;
                        win_cnt[s] = sz;
                    end
                end
            end
        end

        if (rsn != RSN_NONE) begin
            push_result(KIND_DROP, rsn, p.seq, p.hnd, p.pos, 1'b0);
            n++;
        end

        while (n < RESULT_LIMIT) begin
            s = int'((base_seq + 32'd1) % WINDOW);
            if (!win_valid[s]) break;
            if (!win_grp[s]) begin
                push_result(KIND_FRAG, RSN_NONE, base_seq + 32'd1, win_hnd[s], '0, 1'b1);
                n++;
                win_valid[s] = 0;
                cursor = 0;
                advance_base(1);
            end else begin
                g = win_slot[s];
                c = win_cnt[s];
                h = (cursor < MAX_FRAGS) ? grp_hnd[g][cursor] : '0;
                done = (cursor + 1 >= c);
                push_result(KIND_FRAG, RSN_NONE, base_seq + 32'd1, h, 4'(cursor), done);
                n++;
                cursor++;
                if (done) begin
                    grp_valid[g] = 0;
                    grp_have[g] = '0;
                    win_valid[s] = 0;
                    cursor = 0;
                    advance_base((c == 0) ? 1 : c);
                end
            end
        end
        if (n > 0) expected_q[expected_q.size()-1].last = 1'b1;
    endfunction

    // Driver: one descriptor in flight on the command port at a time.
    t_pkt cur_pkt;
    int   wait_cnt = 0;

    function automatic bit launch_ok(t_pkt p, int waited);
        return waited >= p.gap && !(p.hold && expected_q.size() != 0);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            wait_cnt <= 0;
        end else if (start && !busy) begin
            predict_step(cur_pkt);
            accepted <= accepted + 1;
            if (pending_q.size() != 0 && launch_ok(pending_q[0], 0)) begin
                cur_pkt = pending_q.pop_front();
                i_seq_number <= cur_pkt.seq;
                i_frag_count <= cur_pkt.cnt;
                i_frag_pos <= cur_pkt.pos;
                i_group_id <= cur_pkt.gid;
                i_payload_handle <= cur_pkt.hnd;
            end else begin
                start <= 1'b0;
            end
            wait_cnt <= 0;
        end else if (!start && pending_q.size() != 0) begin
            if (launch_ok(pending_q[0], wait_cnt)) begin
                cur_pkt = pending_q.pop_front();
                start <= 1'b1;
                i_seq_number <= cur_pkt.seq;
                i_frag_count <= cur_pkt.cnt;
                i_frag_pos <= cur_pkt.pos;
                i_group_id <= cur_pkt.gid;
                i_payload_handle <= cur_pkt.hnd;
                wait_cnt <= 0;
            end else begin
                wait_cnt <= wait_cnt + 1;
            end
        end
    end

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    // Monitor: results cannot be held off, so every strobe is taken.
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_valid) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual seq %0h",
                         $time, o_packet_seq);
                errors++;
            end else begin
                e = expected_q.pop_front();
                results_seen++;
                if (e.kind == KIND_DROP) drops_seen++;
                check_field("kind", e.kind, o_kind);
                check_field("drop_reason", e.reason, o_drop_reason);
                check_field("packet_seq", e.seq, o_packet_seq);
                check_field("fragment_handle", e.handle, o_fragment_handle);
                check_field("fragment_index", e.idx, o_fragment_index);
                check_field("last_of_packet", e.last_of_packet, o_last_of_packet);
                check_field("last", e.last, o_last);
            end
        end
    end

    task automatic add_pkt(logic [31:0] sq, logic [4:0] c, logic [3:0] ps,
                           logic [31:0] gid, logic [9:0] h, int gap, bit hold);
        t_pkt p;
        p.seq = sq;
        p.cnt = c;
        p.pos = ps;
        p.gid = gid;
        p.hnd = h;
        p.gap = gap;
        p.hold = hold;
        pending_q.insert(pending_q.size(), p);
    endtask

    task automatic wait_idle();
        while (pending_q.size() != 0 || start) @(posedge i_clk);
        while (expected_q.size() != 0) @(posedge i_clk);
        // An item may cause no result yet still occupy the sequencer.
        repeat (20) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic write_start_seq(logic [31:0] v);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= '0;
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        base_seq = v;
        clear_tables();
        @(posedge i_clk);
        psel <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== v) begin
            $display("%0t: start_sequence readback mismatch, expected %0h, actual %0h",
                     $time, v, prdata);
            errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // One burst of well-formed traffic around the current base, shuffled, with
    // occasional holes, repeats and junk descriptors mixed in.
    task automatic make_burst(bit wide_group, ref int count);
        t_pkt        burst[$];
        t_pkt        p, tmp;
        logic [31:0] nxt, gid;
        int          span, k, j, limit;
        bit          no_gaps;
        no_gaps = ($urandom_range(0, 2) == 0);
        nxt = base_seq + 32'd1;
        span = 0;
        limit = wide_group ? 16 : 12;
        while (span < limit) begin
            if (wide_group) begin
                k = 16;
            end else if ($urandom_range(0, 9) < 5) begin
                k = 0;
            end else begin
                k = $urandom_range(1, 4);
                if (k > limit - span) k = limit - span;
            end
            gid = $urandom;
            if ($urandom_range(0, 7) == 0) begin
                // Leave a hole so later packets wait in the window.
                nxt = nxt + 32'd1;
                span++;
            end else if (k == 0) begin
                p.seq = nxt; p.cnt = 0; p.pos = 4'($urandom_range(0, 15)); p.gid = $urandom;
                p.hnd = 10'($urandom); burst.insert(burst.size(), p);
                nxt = nxt + 32'd1;
                span++;
            end else begin
                for (j = 0; j < k; j++) begin
                    p.seq = nxt + 32'(j); p.cnt = 5'(k); p.pos = 4'(j); p.gid = gid;
                    p.hnd = 10'($urandom); burst.insert(burst.size(), p);
                end
                nxt = nxt + 32'(k);
                span += k;
            end
            wide_group = 0;
        end
        if (burst.size() != 0 && $urandom_range(0, 3) == 0)
            burst.insert(burst.size(), burst[$urandom_range(0, burst.size() - 1)]);
        if ($urandom_range(0, 4) == 0) begin
            p.seq = ($urandom_range(0, 1) == 0) ? $urandom : base_seq + 32'($urandom_range(0, 24));
            p.cnt = 5'($urandom_range(0, 31)); p.pos = 4'($urandom); p.gid = $urandom;
            p.hnd = 10'($urandom); burst.insert(burst.size(), p);
        end
        for (j = burst.size() - 1; j > 0; j--) begin
            k = $urandom_range(0, j);
            tmp = burst[j]; burst[j] = burst[k]; burst[k] = tmp;
        end
        for (j = 0; j < burst.size(); j++) begin
            burst[j].gap = no_gaps ? 0 : $urandom_range(0, 9);
            burst[j].hold = (j == 0);
            pending_q.insert(pending_q.size(), burst[j]);
        end
        count += burst.size();
        wait_idle();
    endtask

    initial begin
        logic [31:0] starts[4];
        int          rand_items;
        int          phase_items;
        rand_items = 0;
        base_seq = '0;
        clear_tables();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_start_seq(32'd0);
        add_pkt(32'd1, 5'd0, 4'd0, 32'd0, 10'h3FF, 0, 0);      // in order
        add_pkt(32'd1, 5'd0, 4'd0, 32'd0, 10'h000, 3, 0);      // duplicate, old
        add_pkt(32'd3, 5'd0, 4'd0, 32'd0, 10'h005, 0, 0);      // waits for 2
        add_pkt(32'd2, 5'd0, 4'd0, 32'd0, 10'h006, 9, 0);      // releases 2 and 3
        add_pkt(32'd20, 5'd0, 4'd0, 32'd0, 10'h007, 0, 0);     // beyond window
        add_pkt(32'd4, 5'd17, 4'd0, 32'hFFFF_FFFF, 10'h2AA, 1, 0);  // count too big
        add_pkt(32'd4, 5'd2, 4'd2, 32'h1, 10'h155, 0, 0);      // position past count
        add_pkt(32'd5, 5'd2, 4'd1, 32'hA, 10'h008, 0, 0);
        add_pkt(32'd5, 5'd2, 4'd1, 32'hA, 10'h009, 2, 0);      // duplicate fragment
        add_pkt(32'd4, 5'd2, 4'd0, 32'hA, 10'h00A, 0, 0);      // group completes
        add_pkt(32'd6, 5'd3, 4'd0, 32'hB, 10'h00B, 0, 1);
        add_pkt(32'd7, 5'd5, 4'd3, 32'hB, 10'h00C, 0, 0);      // first size rules
        add_pkt(32'd8, 5'd2, 4'd1, 32'hC, 10'h00D, 5, 0);
        add_pkt(32'd9, 5'd2, 4'd1, 32'hD, 10'h00E, 0, 0);
        add_pkt(32'd10, 5'd2, 4'd1, 32'hE, 10'h00F, 0, 0);
        add_pkt(32'd11, 5'd2, 4'd15, 32'hF, 10'h010, 0, 0);    // bad position
        add_pkt(32'd11, 5'd16, 4'd15, 32'hF, 10'h010, 0, 0);   // table full
        wait_idle();

        write_start_seq(32'd100);
        // Group whose first sequence has gone old by completion.
        add_pkt(32'd101, 5'd2, 4'd0, 32'h60, 10'h001, 0, 0);
        add_pkt(32'd101, 5'd0, 4'd0, 32'd0, 10'h002, 0, 0);
        add_pkt(32'd102, 5'd2, 4'd1, 32'h60, 10'h003, 0, 0);
        // Group whose window slot is already taken.
        add_pkt(32'd103, 5'd2, 4'd0, 32'h61, 10'h004, 0, 0);
        add_pkt(32'd103, 5'd0, 4'd0, 32'd0, 10'h005, 0, 0);
        add_pkt(32'd104, 5'd2, 4'd1, 32'h61, 10'h006, 0, 0);
        // Skipped range discards the packet stored at 103.
        add_pkt(32'd105, 5'd0, 4'd0, 32'd0, 10'h007, 0, 0);
        add_pkt(32'd102, 5'd3, 4'd0, 32'h62, 10'h008, 0, 0);
        add_pkt(32'd104, 5'd3, 4'd1, 32'h62, 10'h009, 0, 0);
        add_pkt(32'd104, 5'd3, 4'd2, 32'h62, 10'h00A, 0, 0);
        wait_idle();

        starts[0] = $urandom;
        starts[1] = 32'hFFFF_FFE8;
        starts[2] = 32'hFFFF_FFFF;
        starts[3] = 32'd0;
        for (int ph = 0; ph < 4; ph++) begin
            write_start_seq(starts[ph]);
            phase_items = 0;
            make_burst(1'b1, phase_items);
            while (phase_items < ((ph == 2) ? 12 : 25)) make_burst(1'b0, phase_items);
            rand_items += phase_items;
        end

        $display("Covered %0d descriptors (%0d random) over six start sequences.",
                 accepted, rand_items);
        $display("Checked %0d results, %0d of them drop reports.", results_seen, drops_seen);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("packet_reorder_reassembly_top regression: pass");
        end else begin
            $display("packet_reorder_reassembly_top regression: fail");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("Timed out with %0d results outstanding.", expected_q.size());
        $display("packet_reorder_reassembly_top regression: fail");
        $finish;
    end

endmodule
